// ----- sv/dssa_pkg.sv -----
// dssa_pkg: shared types and codes for the dual stack block
// no dependencies; imported by the top level
package dssa_pkg;

  // input word and result field widths
  localparam int unsigned OpW   = 3;
  localparam int unsigned WordW = 32;
  localparam int unsigned StatW = 2;

  // request codes
  typedef enum logic [OpW-1:0] {
    OP_PUSH_LO = 3'd0,
    OP_POP_LO  = 3'd1,
    OP_DUMP_LO = 3'd2,
    OP_PUSH_HI = 3'd3,
    OP_POP_HI  = 3'd4,
    OP_DUMP_HI = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_e;

endpackage

// ----- sv/dssa_if.sv -----
// dssa_in_if and dssa_out_if: valid/ready channels of the dual stack block
// no dependencies
interface dssa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface dssa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data_out;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output data_out, output status, output last, input ready);
  modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

// ----- sv/dual_stack_shared_array_top.sv -----
// dual_stack_shared_array_top: two lifo stacks sharing one synchronous memory
// depends on dssa_pkg and the channel interfaces in dssa_if.sv
// first result: loaded into the output register from the emit state
// requests: a new one is taken only once the previous one has handed
// its last result to the output register; a dump gives one word per cycle
// while the output register is free and holds the input until its last word;
// reset: asynchronous, both stack counts clear; memory contents are not reset
module dual_stack_shared_array_top
  import dssa_pkg::*;
#(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dssa_in_if.sink    in_i,
  dssa_out_if.source out_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MAXW = (DATA_WIDTH > WordW) ? DATA_WIDTH : WordW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wdata;

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] low_cnt_q, low_cnt_d;
  logic [CW-1:0] high_cnt_q, high_cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          dump_hi_q, dump_hi_d;
  status_e       pend_stat_q, pend_stat_d;
  logic          pend_last_q, pend_last_d;
  logic          pend_mem_q, pend_mem_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [WordW-1:0]     out_data_q, out_data_d;
  status_e              out_stat_q, out_stat_d;
  logic                 out_last_q, out_last_d;

  logic                 slot_free;
  logic                 in_fire;
  logic [CW:0]          used;
  logic [CW-1:0]        dump_cnt;
  logic [CW-1:0]        low_dec, high_dec, high_idx;
  logic signed [MAXW-1:0] push_ext;
  logic [MAXW-1:0]      rdata_ext;

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;

  assign used      = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
  assign dump_cnt  = dump_hi_q ? high_cnt_q : low_cnt_q;
  assign low_dec   = low_cnt_q - CW'(1);
  assign high_dec  = DepthC - high_cnt_q - CW'(1);
  assign high_idx  = DepthC - CW'(1) - idx_q;

  // sign extend the pushed word, widen the stored word for the result
  assign push_ext  = MAXW'(in_i.push_value);
  assign wdata     = push_ext[DATA_WIDTH-1:0];
  assign rdata_ext = MAXW'(rdata_q);

  // memory: one write and one registered read per cycle; a request only
  // starts once the previous one is done, so a read never meets a write
  // to the same entry in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // state and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_cnt_q   <= '0;
      high_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_cnt_q   <= low_cnt_d;
      high_cnt_q  <= high_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    dump_hi_q   <= dump_hi_d;
    pend_stat_q <= pend_stat_d;
    pend_last_q <= pend_last_d;
    pend_mem_q  <= pend_mem_d;
    out_data_q  <= out_data_d;
    out_stat_q  <= out_stat_d;
    out_last_q  <= out_last_d;
  end

  // request decode and result sequencing
  always_comb begin
    state_d     = state_q;
    low_cnt_d   = low_cnt_q;
    high_cnt_d  = high_cnt_q;
    idx_d       = idx_q;
    dump_hi_d   = dump_hi_q;
    pend_stat_d = pend_stat_q;
    pend_last_d = pend_last_q;
    pend_mem_d  = pend_mem_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pend_stat_d = ST_OK;
          pend_last_d = 1'b1;
          pend_mem_d  = 1'b0;
          state_d     = S_EMIT;
          unique case (in_i.op)
            OP_PUSH_LO, OP_PUSH_HI: begin
              if (used >= {1'b0, DepthC}) begin
                pend_stat_d = ST_OVERFLOW;
              end else if (in_i.op == OP_PUSH_LO) begin
                wr_en     = 1'b1;
                wr_addr   = low_cnt_q[AW-1:0];
                low_cnt_d = low_cnt_q + CW'(1);
              end else begin
                wr_en      = 1'b1;
                wr_addr    = high_dec[AW-1:0];
                high_cnt_d = high_cnt_q + CW'(1);
              end
            end
            OP_POP_LO: begin
              if (low_cnt_q == '0) begin
                pend_stat_d = ST_UNDERFLOW;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = low_dec[AW-1:0];
                low_cnt_d  = low_dec;
                pend_mem_d = 1'b1;
              end
            end
            OP_POP_HI: begin
              if (high_cnt_q == '0) begin
                pend_stat_d = ST_UNDERFLOW;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = high_dec[AW-1:0] + AW'(1);
                high_cnt_d = high_cnt_q - CW'(1);
                pend_mem_d = 1'b1;
              end
            end
            OP_DUMP_LO, OP_DUMP_HI: begin
              dump_hi_d = (in_i.op == OP_DUMP_HI);
              if ((in_i.op == OP_DUMP_HI) ? (high_cnt_q == '0) : (low_cnt_q == '0)) begin
                pend_stat_d = ST_EMPTY;
              end else begin
                // first word: entry 0 or entry DEPTH-1, the bottom of the chosen stack
                rd_en       = 1'b1;
                rd_addr     = (in_i.op == OP_DUMP_HI) ? AW'(DEPTH - 1) : '0;
                idx_d       = CW'(1);
                pend_mem_d  = 1'b1;
                pend_last_d = (in_i.op == OP_DUMP_HI) ? (high_cnt_q == CW'(1))
                                                      : (low_cnt_q == CW'(1));
              end
            end
            default: begin
              // unused codes give nothing
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = pend_mem_q ? rdata_ext[WordW-1:0] : '0;
          out_stat_d  = pend_stat_q;
          out_last_d  = pend_last_q;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end else begin
            // next dump word
            rd_en       = 1'b1;
            rd_addr     = dump_hi_q ? high_idx[AW-1:0] : idx_q[AW-1:0];
            idx_d       = idx_q + CW'(1);
            pend_last_d = ((idx_q + CW'(1)) == dump_cnt);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.status   = out_stat_q;
  assign out_o.last     = out_last_q;

endmodule
